// ===== sv/accel_tilt_pitch_roll_unit_macros.svh =====
// Assertion macros shared by the tilt angle unit.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ACCEL_TILT_PITCH_ROLL_UNIT_MACROS_SVH
`define ACCEL_TILT_PITCH_ROLL_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ATPR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ATPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/atpr_pkg.sv =====
// Shared types and constants of the tilt angle unit.
// No dependencies; every module of the unit imports this package.
`timescale 1ns / 1ps

package atpr_pkg;

  // Vector lanes hold the input count with 20 fraction bits.
  localparam int VEC_W      = 40;
  localparam int IN_W       = 17;
  localparam int FRAC_SHIFT = 20;
  // Angle accumulator: degrees with 23 fraction bits.
  localparam int ANG_W      = 32;
  localparam int ANG_DROP   = 16;
  localparam int OUT_W      = 16;

  localparam logic signed [ANG_W-1:0] ROUND_BIAS    = 32'sd32768;
  localparam logic signed [IN_W-1:0]  HALF_TURN     = 17'sd23040;
  localparam logic signed [IN_W-1:0]  NEG_HALF_TURN = -17'sd23040;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic signed [IN_W-1:0]  base;   // half-plane offset in 1/128 degree
    logic                    fixed;  // result is the offset alone
  } lane_t;

  typedef struct packed {
    lane_t pitch;
    lane_t roll;
  } pair_t;

  // atan(2^-i) in degrees with 23 fraction bits, for stages 0 to 23.
  function automatic logic signed [ANG_W-1:0] stage_angle(input logic [4:0] idx);
    logic signed [ANG_W-1:0] ang;
    case (idx)
      5'd0:    ang = 32'sd377487360;
      5'd1:    ang = 32'sd222843801;
      5'd2:    ang = 32'sd117744544;
      5'd3:    ang = 32'sd59768969;
      5'd4:    ang = 32'sd30000467;
      5'd5:    ang = 32'sd15014858;
      5'd6:    ang = 32'sd7509261;
      5'd7:    ang = 32'sd3754860;
      5'd8:    ang = 32'sd1877459;
      5'd9:    ang = 32'sd938733;
      5'd10:   ang = 32'sd469367;
      5'd11:   ang = 32'sd234683;
      5'd12:   ang = 32'sd117342;
      5'd13:   ang = 32'sd58671;
      5'd14:   ang = 32'sd29335;
      5'd15:   ang = 32'sd14668;
      5'd16:   ang = 32'sd7334;
      5'd17:   ang = 32'sd3667;
      5'd18:   ang = 32'sd1833;
      5'd19:   ang = 32'sd917;
      5'd20:   ang = 32'sd458;
      5'd21:   ang = 32'sd229;
      5'd22:   ang = 32'sd115;
      5'd23:   ang = 32'sd57;
      default: ang = '0;
    endcase
    return ang;
  endfunction

endpackage

// ===== sv/accel_tilt_pitch_roll_unit.sv =====
// Top level of the accelerometer tilt angle unit.
// Depends on atpr_pkg, atpr_prep, atpr_cell, atpr_post and the assertion macro header.
`timescale 1ns / 1ps
`include "accel_tilt_pitch_roll_unit_macros.svh"

// Gives pitch = atan2(x, z) and roll = -atan2(-y, z) for each accelerometer request,
// in signed units of 1/128 degree within -180 to +180 degrees. It takes one request
// per clock while in_stall is low and passes it through an input register that
// folds the vectors into the right half plane, one register per CORDIC stage (both
// angles are worked side by side in each stage), and the output register that
// rounds and clamps. A stall at the output holds only the stages that are full;
// empty stages keep filling, so in_stall rises only once the whole row is occupied.
module accel_tilt_pitch_roll_unit
  import atpr_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [OUT_W-1:0] in_accel_x,
  input  logic signed [OUT_W-1:0] in_accel_y,
  input  logic signed [OUT_W-1:0] in_accel_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_pitch_angle,
  output logic signed [OUT_W-1:0] out_roll_angle
);

  logic  stg_valid [CORDIC_STAGES+1];
  logic  stg_ready [CORDIC_STAGES+1];
  pair_t stg_data  [CORDIC_STAGES+1];
  logic  prep_ready;

  atpr_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (prep_ready),
    .accel_x  (in_accel_x),
    .accel_y  (in_accel_y),
    .accel_z  (in_accel_z),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0]),
    .dn_data  (stg_data[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    atpr_cell #(
      .STAGE (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[k]),
      .up_ready (stg_ready[k]),
      .up_data  (stg_data[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_ready (stg_ready[k+1]),
      .dn_data  (stg_data[k+1])
    );
  end

  atpr_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (stg_valid[CORDIC_STAGES]),
    .up_ready    (stg_ready[CORDIC_STAGES]),
    .up_data     (stg_data[CORDIC_STAGES]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pitch_angle (out_pitch_angle),
    .roll_angle  (out_roll_angle)
  );

  assign in_stall = !prep_ready;

  // With the output draining, every stage moves, so the input must be open.
  `ATPR_ASSERT_IMPLIES(a_open_when_draining, !out_stall, !in_stall, "input stalled while output drains")

endmodule

// ===== sv/atpr_prep.sv =====
// Input stage of the tilt angle unit: folds both vectors into the right half plane.
// Depends on atpr_pkg.
`timescale 1ns / 1ps

module atpr_prep
  import atpr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [OUT_W-1:0] accel_x,
  input  logic signed [OUT_W-1:0] accel_y,
  input  logic signed [OUT_W-1:0] accel_z,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output pair_t                   dn_data
);

  logic  v_r;
  pair_t d_r;
  pair_t d_nxt;

  // Sets up the vector for atan2(a, b).
  function automatic lane_t fold(input logic signed [IN_W-1:0] a,
                                 input logic signed [IN_W-1:0] b);
    lane_t                  ln;
    logic signed [IN_W-1:0] vx;
    logic signed [IN_W-1:0] vy;
    ln.base = '0;
    vx = b;
    vy = a;
    if (b < 0) begin
      ln.base = (a >= 0) ? HALF_TURN : NEG_HALF_TURN;
      vx = -b;
      vy = -a;
    end
    // A zero first argument leaves only the offset, which covers the origin too.
    ln.fixed = (a == 0);
    ln.x = {{(VEC_W-IN_W-FRAC_SHIFT){vx[IN_W-1]}}, vx, {FRAC_SHIFT{1'b0}}};
    ln.y = {{(VEC_W-IN_W-FRAC_SHIFT){vy[IN_W-1]}}, vy, {FRAC_SHIFT{1'b0}}};
    ln.z = '0;
    return ln;
  endfunction

  always_comb begin
    d_nxt.pitch = fold({accel_x[OUT_W-1], accel_x}, {accel_z[OUT_W-1], accel_z});
    d_nxt.roll  = fold(-$signed({accel_y[OUT_W-1], accel_y}),
                       {accel_z[OUT_W-1], accel_z});
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

// ===== sv/atpr_cell.sv =====
// One CORDIC vectoring stage for the pitch and roll lanes, with its pipeline register.
// Depends on atpr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "accel_tilt_pitch_roll_unit_macros.svh"

module atpr_cell
  import atpr_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  pair_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output pair_t dn_data
);

  localparam logic signed [ANG_W-1:0] ANG = stage_angle(5'(STAGE));

  logic  v_r;
  pair_t d_r;
  pair_t d_nxt;

  // Rotates toward the x axis; arithmetic shifts round toward minus infinity.
  function automatic lane_t rotate(input lane_t ln);
    lane_t                   res;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    res = ln;
    dx = ln.y >>> STAGE;
    dy = ln.x >>> STAGE;
    if (ln.y > 0) begin
      res.x = ln.x + dx;
      res.y = ln.y - dy;
      res.z = ln.z + ANG;
    end else begin
      res.x = ln.x - dx;
      res.y = ln.y + dy;
      res.z = ln.z - ANG;
    end
    return res;
  endfunction

  always_comb begin
    d_nxt.pitch = rotate(up_data.pitch);
    d_nxt.roll  = rotate(up_data.roll);
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // The x component only ever grows from a non-negative start.
  `ATPR_ASSERT_IMPLIES(a_x_nonneg, v_r, !d_r.pitch.x[VEC_W-1] && !d_r.roll.x[VEC_W-1], "x went negative")

endmodule

// ===== sv/atpr_post.sv =====
// Output stage of the tilt angle unit: rounds, adds the half-plane offset, clamps and negates roll.
// Depends on atpr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "accel_tilt_pitch_roll_unit_macros.svh"

module atpr_post
  import atpr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  pair_t                   up_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] pitch_angle,
  output logic signed [OUT_W-1:0] roll_angle
);

  logic                    out_valid_r;
  logic signed [OUT_W-1:0] pitch_r;
  logic signed [OUT_W-1:0] roll_r;
  logic signed [IN_W-1:0]  pitch_nxt;
  logic signed [IN_W-1:0]  roll_ang;
  logic signed [IN_W-1:0]  roll_nxt;

  function automatic logic signed [IN_W-1:0] finish(input lane_t ln);
    logic signed [ANG_W-1:0] zr;
    logic signed [IN_W-1:0]  sum;
    logic signed [IN_W-1:0]  res;
    zr  = (ln.z + ROUND_BIAS) >>> ANG_DROP;
    sum = ln.base + zr[IN_W-1:0];
    if (ln.fixed) begin
      res = ln.base;
    end else if (sum > HALF_TURN) begin
      res = HALF_TURN;
    end else if (sum < NEG_HALF_TURN) begin
      res = NEG_HALF_TURN;
    end else begin
      res = sum;
    end
    return res;
  endfunction

  always_comb begin
    pitch_nxt = finish(up_data.pitch);
    roll_ang  = finish(up_data.roll);
    roll_nxt  = -roll_ang;
  end

  assign up_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pitch_r <= pitch_nxt[OUT_W-1:0];
      roll_r  <= roll_nxt[OUT_W-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign pitch_angle = pitch_r;
  assign roll_angle  = roll_r;

  `ATPR_ASSERT_NEXT(a_load_shows, up_valid && up_ready, out_valid_r, "request lost at output")
  `ATPR_ASSERT_IMPLIES(a_range, out_valid_r, (pitch_r <= 16'sd23040) && (pitch_r >= -16'sd23040) && (roll_r <= 16'sd23040) && (roll_r >= -16'sd23040), "angle out of range")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the accelerometer tilt angle unit (pitch and roll).
// Depends on atpr_pkg and accel_tilt_pitch_roll_unit; it predicts each result
// with its own fixed-point CORDIC and compares every output request against it.
`timescale 1ns / 1ps

module tb_top;

  localparam int W            = atpr_pkg::OUT_W;
  localparam int STAGES       = 16;
  localparam int N_RANDOM     = 500;
  localparam int DRAIN_CYCLES = 2 * (STAGES + 2) + 8;
  localparam int CYCLE_LIMIT  = 200000;

  localparam longint HALF_TURN_UNITS = 23040;
  localparam longint VEC_ONE         = 1048576;

  typedef logic signed [W-1:0] axis_t;

  typedef struct {
    axis_t x;
    axis_t y;
    axis_t z;
    bit    drain;  // hold this request back until every result is in
  } sample_t;

  typedef struct {
    axis_t pitch;
    axis_t roll;
  } angles_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  axis_t in_accel_x = '0;
  axis_t in_accel_y = '0;
  axis_t in_accel_z = '0;
  logic  out_valid;
  logic  out_stall  = 1'b0;
  axis_t out_pitch_angle;
  axis_t out_roll_angle;

  sample_t pending_q[$];
  angles_t angles_q[$];

  int sent_cnt      = 0;
  int recv_cnt      = 0;
  int n_items       = 0;
  int errors        = 0;
  int cycle_cnt     = 0;
  int in_stall_cnt  = 0;
  int out_stall_cnt = 0;
  int burst_left    = 0;
  int gap_left      = 0;

  bit          take;
  sample_t     nxt;
  angles_t     want;
  stall_mode_e stall_mode;

  accel_tilt_pitch_roll_unit #(
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_accel_z     (in_accel_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pitch_angle(out_pitch_angle),
    .out_roll_angle (out_roll_angle)
  );

  always #5 clk = ~clk;

  // atan(2^-i) in degrees with 23 fraction bits, built from the truncated series.
  function automatic longint stage_deg(input int i);
    longint unsigned pos, neg, rad, deg40, term;
    int k, e;
    pos = 0;
    neg = 0;
    if (i == 0) return longint'(64'd45 * 64'd8388608);
    for (k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 40) break;
      term = (64'd1 << (40 - e)) / longint'(unsigned'(2 * k + 1));
      if ((k % 2) == 0) pos += term;
      else neg += term;
    end
    rad   = pos - neg;
    deg40 = rad * 64'd5958360 / 64'd103993;
    return longint'((deg40 + 64'd65536) >> 17);
  endfunction

  // atan2(a, b) in units of 1/128 degree.
  function automatic longint tilt_atan2(input longint a, input longint b);
    longint base, cx, cy, acc, dx, dy, r;
    int i;
    base = 0;
    acc  = 0;
    cx   = b;
    cy   = a;
    if (a == 0 && b == 0) return 0;
    if (b < 0) begin
      base = (a >= 0) ? HALF_TURN_UNITS : -HALF_TURN_UNITS;
      cx   = -b;
      cy   = -a;
    end
    if (cy == 0) return base;
    cx = cx * VEC_ONE;
    cy = cy * VEC_ONE;
    for (i = 0; i < STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx  += dx;
        cy  -= dy;
        acc += stage_deg(i);
      end else begin
        cx  -= dx;
        cy  += dy;
        acc -= stage_deg(i);
      end
    end
    r = base + ((acc + 64'sd32768) >>> 16);
    if (r > HALF_TURN_UNITS) r = HALF_TURN_UNITS;
    if (r < -HALF_TURN_UNITS) r = -HALF_TURN_UNITS;
    return r;
  endfunction

  function automatic angles_t predict_tilt(input axis_t ax, input axis_t ay, input axis_t az);
    angles_t res;
    longint p, q;
    p = tilt_atan2(longint'(ax), longint'(az));
    q = -tilt_atan2(-longint'(ay), longint'(az));
    res.pitch = axis_t'(p);
    res.roll  = axis_t'(q);
    return res;
  endfunction

  function automatic axis_t rand_axis(input int kind);
    int pick;
    case (kind)
      0: rand_axis = axis_t'($urandom());
      1: rand_axis = axis_t'(int'($urandom_range(0, 16)) - 8);
      default: begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: rand_axis = -16'sd32768;
          1: rand_axis = -16'sd1;
          2: rand_axis = 16'sd0;
          3: rand_axis = 16'sd1;
          default: rand_axis = 16'sd32767;
        endcase
      end
    endcase
  endfunction

  task automatic add_sample(input axis_t x, input axis_t y, input axis_t z, input bit drain);
    sample_t s;
    s.x     = x;
    s.y     = y;
    s.z     = z;
    s.drain = drain;
    pending_q.push_back(s);
    n_items++;
  endtask

  // Sender: bursts of requests with random gaps in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      if (in_valid && in_stall) in_stall_cnt <= in_stall_cnt + 1;
      if (take) begin
        angles_q.push_back(predict_tilt(in_accel_x, in_accel_y, in_accel_z));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid || take) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_q[0].drain && (in_valid || sent_cnt != recv_cnt)) begin
          in_valid <= 1'b0;
        end else begin
          nxt = pending_q.pop_front();
          in_valid   <= 1'b1;
          in_accel_x <= nxt.x;
          in_accel_y <= nxt.y;
          in_accel_z <= nxt.z;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: the stall pattern steps through none, light, periodic and heavy in turn.
  always @(posedge clk) begin
    stall_mode = stall_mode_e'((cycle_cnt / 300) % 4);
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
      STALL_PERIODIC: out_stall <= ((cycle_cnt % 7) < 3);
      default:        out_stall <= ($urandom_range(0, 99) < 75);
    endcase
    if (out_valid && out_stall) out_stall_cnt <= out_stall_cnt + 1;
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      recv_cnt <= recv_cnt + 1;
      if (angles_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pitch %0d roll %0d", $time,
                 out_pitch_angle, out_roll_angle);
      end else begin
        want = angles_q.pop_front();
        if (out_pitch_angle !== want.pitch) begin
          errors++;
          $display("%0t: pitch mismatch expected %0d actual %0d", $time,
                   want.pitch, out_pitch_angle);
        end
        if (out_roll_angle !== want.roll) begin
          errors++;
          $display("%0t: roll mismatch expected %0d actual %0d", $time,
                   want.roll, out_roll_angle);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int i, kind;
    // Both axes zero, zero first argument with either sign of z, and the folds.
    add_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
    add_sample(16'sd0, 16'sd0, -16'sd1, 1'b0);
    add_sample(16'sd0, 16'sd0, 16'sd1, 1'b0);
    add_sample(16'sd0, 16'sd0, -16'sd32768, 1'b0);
    add_sample(16'sd0, 16'sd0, 16'sd32767, 1'b0);
    add_sample(16'sd0, 16'sd5, -16'sd300, 1'b0);
    add_sample(16'sd7, 16'sd0, -16'sd300, 1'b0);
    add_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    add_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    add_sample(-16'sd32768, 16'sd0, 16'sd0, 1'b0);
    add_sample(16'sd32767, -16'sd32768, -16'sd32768, 1'b0);
    add_sample(16'sd0, -16'sd32768, 16'sd0, 1'b0);
    add_sample(16'sd0, 16'sd32767, 16'sd0, 1'b0);
    add_sample(16'sd1, 16'sd1, -16'sd32768, 1'b0);
    add_sample(-16'sd1, -16'sd1, -16'sd32768, 1'b0);
    add_sample(16'sd32767, 16'sd0, 16'sd1, 1'b0);
    add_sample(-16'sd32768, 16'sd0, -16'sd1, 1'b0);
    add_sample(16'sd1, -16'sd1, 16'sd0, 1'b0);
    add_sample(-16'sd1, 16'sd1, 16'sd0, 1'b0);
    add_sample(16'sd100, 16'sd200, 16'sd300, 1'b0);
    add_sample(-16'sd32768, 16'sd32767, -16'sd1, 1'b0);
    // This one always waits until the pipeline has emptied.
    add_sample(16'sd12345, -16'sd23456, 16'sd4321, 1'b1);
    // Random part; a few requests wait for the pipeline to empty first.
    for (i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        add_sample(rand_axis(0), rand_axis(0), rand_axis(0),
                   (i == 0) || (i == 150) || (i == 350));
      end else if (kind < 7) begin
        add_sample(rand_axis(1), rand_axis(1), rand_axis(1), i == 150);
      end else if (kind == 7) begin
        // One of x or y zero with a random z exercises the exact offsets.
        if ($urandom_range(0, 1))
          add_sample(16'sd0, rand_axis(0), rand_axis(0), 1'b0);
        else
          add_sample(rand_axis(0), 16'sd0, rand_axis(0), 1'b0);
      end else if (kind == 8) begin
        add_sample(rand_axis(0), rand_axis(0), 16'sd0, 1'b0);
      end else begin
        add_sample(rand_axis(2), rand_axis(2), rand_axis(2), 1'b0);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (sent_cnt != n_items || recv_cnt < n_items);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (angles_q.size() != 0) begin
      errors += angles_q.size();
      $display("%0t: %0d expected results never arrived", $time, angles_q.size());
    end

    $display("Sent %0d accelerometer requests (zero vectors, half-plane folds, extremes)",
             n_items);
    $display("and checked %0d results; %0d input stall and %0d output stall cycles seen.",
             recv_cnt, in_stall_cnt, out_stall_cnt);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
